[src/lr_pkg.sv]
// Shared types and constants for the line rasterizer.
// Depends on nothing; every other file in src refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

    // Fixed field widths of the payload and configuration registers.
    localparam int COORD_BITS     = 10;
    localparam int ADDR_BITS      = 20;
    localparam int PITCH_BITS     = 10;
    localparam int COLOR_BITS     = 8;
    localparam int CFG_INDEX_BITS = 1;

    // Decision value and its increments lie within plus or minus twice a coordinate span.
    localparam int DEC_BITS = COORD_BITS + 2;

    localparam logic [PITCH_BITS-1:0] PITCH_RESET = PITCH_BITS'(320);

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic [ADDR_BITS-1:0]       addr_t;
    typedef logic [PITCH_BITS-1:0]      pitch_t;
    typedef logic [COLOR_BITS-1:0]      color_t;
    typedef logic signed [DEC_BITS-1:0] dec_t;

    // Operation carried by an input item.
    typedef enum logic {
        OP_LINE = 1'b0,
        OP_TICK = 1'b1
    } op_e;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FRAME_BASE = 1'b0,
        REG_ROW_PITCH  = 1'b1
    } cfg_reg_e;

    // One input item.
    typedef struct packed {
        op_e    op;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        color_t pen_color;
    } item_t;

    // One result item.
    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        addr_t  pixel_address;
        color_t pixel_color;
        logic   last;
    } pixel_t;

    // Classified command as it travels from the front end to the stepper.
    typedef struct packed {
        op_e    op;
        coord_t x;
        coord_t y;
        coord_t major_end;
        logic   steep;
        logic   minor_down;
        logic   first_last;
        dec_t   decision;
        dec_t   straight_incr;
        dec_t   diag_incr;
        color_t color;
    } cmd_t;

    // Configuration register contents seen by the back end.
    typedef struct packed {
        addr_t  frame_base;
        pitch_t row_pitch;
    } cfg_t;

endpackage

`default_nettype wire

[src/line_rasterizer.sv]
// Line rasterizer top level: configuration registers, front end, queue and stepper.
// Depends on lr_pkg, lr_front, lr_queue and lr_back.
`timescale 1ns / 1ps
`default_nettype none

// Midpoint line drawer. A line command (op 0) orders its endpoints by x, works out
// the decision value for the major axis and gives the first pixel; each tick (op 1)
// gives the next pixel, flagged last at the end of the line. A tick while idle gives
// nothing and a new command abandons the running line. One item is taken every
// clock while the output is being taken, since each step is a single add and
// compare in the stepper; from the transfer of its item, a pixel passes through
// the front register, queue, step, row multiply, then the address add into the
// output register. The frame base and row pitch may only be written while no line
// is in flight.
module line_rasterizer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire lr_pkg::item_t    in_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output lr_pkg::pixel_t        out_pixel,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire lr_pkg::cfg_reg_e cfg_index,
    input  wire lr_pkg::addr_t    cfg_data
);

    lr_pkg::addr_t  frame_base_reg, frame_base_next;
    lr_pkg::pitch_t row_pitch_reg, row_pitch_next;
    lr_pkg::cfg_t   cfg;

    logic         f_valid, f_ready;
    lr_pkg::cmd_t f_item;
    logic         q_valid, q_ready;
    lr_pkg::cmd_t q_item;

    // Configuration writes are always taken.
    always_comb
    begin
        cfg_ready       = 1'b1;
        frame_base_next = frame_base_reg;
        row_pitch_next  = row_pitch_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                lr_pkg::REG_FRAME_BASE: frame_base_next = cfg_data;
                lr_pkg::REG_ROW_PITCH:  row_pitch_next  = cfg_data[lr_pkg::PITCH_BITS-1:0];
                default:                frame_base_next = frame_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg <= '0;
            row_pitch_reg  <= lr_pkg::PITCH_RESET;
        end
        else
        begin
            frame_base_reg <= frame_base_next;
            row_pitch_reg  <= row_pitch_next;
        end
    end

    assign cfg.frame_base = frame_base_reg;
    assign cfg.row_pitch  = row_pitch_reg;

    lr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_item  (f_item)
    );

    lr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    lr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd_item  (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_pixel (out_pixel)
    );

endmodule

`default_nettype wire

[src/lr_front.sv]
// Front end of the line rasterizer: accepts input items and sets up line commands.
// Depends on lr_pkg for the item and command types.
`timescale 1ns / 1ps
`default_nettype none

module lr_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire lr_pkg::item_t in_item,
    output logic               cmd_valid,
    input  wire logic          cmd_ready,
    output lr_pkg::cmd_t       cmd_item
);

    logic          valid_reg;
    logic          valid_next;
    lr_pkg::cmd_t  cmd_reg;
    lr_pkg::cmd_t  cmd_next;
    logic          take;

    lr_pkg::coord_t x1, y1, x2, y2;
    lr_pkg::coord_t dx, ady, major, minor;
    logic           swap, down, steep;
    lr_pkg::dec_t   two_minor, two_major, major_ext;

    // Order the endpoints so that x does not decrease, then pick the major axis.
    always_comb
    begin
        swap      = in_item.start_x > in_item.end_x;
        x1        = swap ? in_item.end_x   : in_item.start_x;
        y1        = swap ? in_item.end_y   : in_item.start_y;
        x2        = swap ? in_item.start_x : in_item.end_x;
        y2        = swap ? in_item.start_y : in_item.end_y;
        dx        = x2 - x1;
        down      = y2 < y1;
        ady       = down ? (y1 - y2) : (y2 - y1);
        steep     = ady > dx;
        major     = steep ? ady : dx;
        minor     = steep ? dx : ady;
        two_minor = lr_pkg::dec_t'({1'b0, minor, 1'b0});
        two_major = lr_pkg::dec_t'({1'b0, major, 1'b0});
        major_ext = lr_pkg::dec_t'({2'b00, major});

        cmd_next.op            = in_item.op;
        cmd_next.x             = x1;
        cmd_next.y             = y1;
        cmd_next.major_end     = steep ? y2 : x2;
        cmd_next.steep         = steep;
        cmd_next.minor_down    = down;
        cmd_next.first_last    = (major == '0);
        cmd_next.decision      = two_minor - major_ext;
        cmd_next.straight_incr = two_minor;
        cmd_next.diag_incr     = two_minor - two_major;
        cmd_next.color         = in_item.pen_color;
    end

    // A transfer is taken whenever the holding register is empty or drains this cycle.
    always_comb
    begin
        in_ready   = !valid_reg || cmd_ready;
        take       = in_valid && in_ready;
        valid_next = take || (valid_reg && !cmd_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd_item  = cmd_reg;

endmodule

`default_nettype wire

[src/lr_queue.sv]
// Short command queue between the front end and the stepper of the line rasterizer.
// Depends on lr_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module lr_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push_valid,
    output logic              push_ready,
    input  wire lr_pkg::cmd_t push_item,
    output logic              pop_valid,
    input  wire logic         pop_ready,
    output lr_pkg::cmd_t      pop_item
);

    localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    lr_pkg::cmd_t          entry_reg [DEPTH];
    logic [IDX_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [IDX_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  push, pop;

    // Pointer and fill count bookkeeping.
    always_comb
    begin
        push_ready  = (count_reg != COUNT_BITS'(DEPTH));
        pop_valid   = (count_reg != '0);
        push        = push_valid && push_ready;
        pop         = pop_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item = entry_reg[rd_ptr_reg];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(DEPTH))
        else $error("queue fill count beyond depth");

    a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on a lone push");
`endif

endmodule

`default_nettype wire

[src/lr_back.sv]
// Back end of the line rasterizer: steps the line and forms pixel addresses.
// Depends on lr_pkg for the command, configuration and pixel types.
`timescale 1ns / 1ps
`default_nettype none

module lr_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire lr_pkg::cfg_t cfg,
    input  wire logic         cmd_valid,
    output logic              cmd_ready,
    input  wire lr_pkg::cmd_t cmd_item,
    output logic              out_valid,
    input  wire logic         out_ready,
    output lr_pkg::pixel_t    out_pixel
);

    localparam int PROD_BITS = lr_pkg::PITCH_BITS + lr_pkg::COORD_BITS;
    localparam int SUM_BITS  =
        ((PROD_BITS > lr_pkg::ADDR_BITS) ? PROD_BITS : lr_pkg::ADDR_BITS) + 2;

    // Line state.
    logic           busy_reg, busy_next;
    lr_pkg::coord_t cur_x_reg, cur_x_next;
    lr_pkg::coord_t cur_y_reg, cur_y_next;
    lr_pkg::coord_t major_end_reg, major_end_next;
    logic           steep_reg, steep_next;
    logic           down_reg, down_next;
    lr_pkg::dec_t   decision_reg, decision_next;
    lr_pkg::dec_t   straight_reg, straight_next;
    lr_pkg::dec_t   diag_incr_reg, diag_incr_next;
    lr_pkg::color_t color_reg, color_next;

    // Pixel stage, product stage and output register.
    logic           s1_valid_reg, s1_valid_next;
    lr_pkg::coord_t s1_x_reg, s1_x_next;
    lr_pkg::coord_t s1_y_reg, s1_y_next;
    lr_pkg::color_t s1_color_reg, s1_color_next;
    logic           s1_last_reg, s1_last_next;

    logic                 s2_valid_reg;
    logic [PROD_BITS-1:0] s2_prod_reg;
    lr_pkg::coord_t       s2_x_reg;
    lr_pkg::coord_t       s2_y_reg;
    lr_pkg::color_t       s2_color_reg;
    logic                 s2_last_reg;

    logic           out_valid_reg;
    lr_pkg::pixel_t out_pixel_reg, out_pixel_next;

    logic           advance, pop, diag, step_last;
    lr_pkg::coord_t x_inc, y_step, x_new, y_new;
    logic [SUM_BITS-1:0] addr_sum;

    // The whole back end moves while the output register is free or being emptied.
    always_comb
    begin
        advance   = !out_valid_reg || out_ready;
        cmd_ready = advance;
        pop       = cmd_valid && advance;
    end

    // One midpoint step along the major axis; a tie steps straight.
    always_comb
    begin
        diag      = decision_reg > lr_pkg::dec_t'(0);
        x_inc     = cur_x_reg + 1'b1;
        y_step    = down_reg ? (cur_y_reg - 1'b1) : (cur_y_reg + 1'b1);
        if (steep_reg)
        begin
            y_new = y_step;
            x_new = diag ? x_inc : cur_x_reg;
        end
        else
        begin
            x_new = x_inc;
            y_new = diag ? y_step : cur_y_reg;
        end
        step_last = ((steep_reg ? y_new : x_new) == major_end_reg);
    end

    // Line state update on each command taken from the queue.
    always_comb
    begin
        busy_next      = busy_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        major_end_next = major_end_reg;
        steep_next     = steep_reg;
        down_next      = down_reg;
        decision_next  = decision_reg;
        straight_next  = straight_reg;
        diag_incr_next = diag_incr_reg;
        color_next     = color_reg;
        s1_valid_next  = s1_valid_reg;
        s1_x_next      = s1_x_reg;
        s1_y_next      = s1_y_reg;
        s1_color_next  = s1_color_reg;
        s1_last_next   = s1_last_reg;
        if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (pop)
        begin
            case (cmd_item.op)
                lr_pkg::OP_LINE:
                begin
                    busy_next      = !cmd_item.first_last;
                    cur_x_next     = cmd_item.x;
                    cur_y_next     = cmd_item.y;
                    major_end_next = cmd_item.major_end;
                    steep_next     = cmd_item.steep;
                    down_next      = cmd_item.minor_down;
                    decision_next  = cmd_item.decision;
                    straight_next  = cmd_item.straight_incr;
                    diag_incr_next = cmd_item.diag_incr;
                    color_next     = cmd_item.color;
                    s1_valid_next  = 1'b1;
                    s1_x_next      = cmd_item.x;
                    s1_y_next      = cmd_item.y;
                    s1_color_next  = cmd_item.color;
                    s1_last_next   = cmd_item.first_last;
                end
                lr_pkg::OP_TICK:
                begin
                    if (busy_reg)
                    begin
                        busy_next     = !step_last;
                        cur_x_next    = x_new;
                        cur_y_next    = y_new;
                        decision_next = decision_reg + (diag ? diag_incr_reg : straight_reg);
                        s1_valid_next = 1'b1;
                        s1_x_next     = x_new;
                        s1_y_next     = y_new;
                        s1_color_next = color_reg;
                        s1_last_next  = step_last;
                    end
                end
                default:
                begin
                    s1_valid_next = 1'b0;
                end
            endcase
        end
    end

    // Address is base plus pitch times row plus column, wrapping at the address width.
    always_comb
    begin
        addr_sum = SUM_BITS'(cfg.frame_base) + SUM_BITS'(s2_prod_reg) + SUM_BITS'(s2_x_reg);
        out_pixel_next.pixel_x       = s2_x_reg;
        out_pixel_next.pixel_y       = s2_y_reg;
        out_pixel_next.pixel_address = addr_sum[lr_pkg::ADDR_BITS-1:0];
        out_pixel_next.pixel_color   = s2_color_reg;
        out_pixel_next.last          = s2_last_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            s1_valid_reg <= s1_valid_next;
            if (advance)
            begin
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Line state and pixel payload registers.
    always_ff @(posedge clk)
    begin
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        major_end_reg <= major_end_next;
        steep_reg     <= steep_next;
        down_reg      <= down_next;
        decision_reg  <= decision_next;
        straight_reg  <= straight_next;
        diag_incr_reg <= diag_incr_next;
        color_reg     <= color_next;
        s1_x_reg      <= s1_x_next;
        s1_y_reg      <= s1_y_next;
        s1_color_reg  <= s1_color_next;
        s1_last_reg   <= s1_last_next;
        if (advance)
        begin
            s2_prod_reg   <= PROD_BITS'(cfg.row_pitch) * PROD_BITS'(s1_y_reg);
            s2_x_reg      <= s1_x_reg;
            s2_y_reg      <= s1_y_reg;
            s2_color_reg  <= s1_color_reg;
            s2_last_reg   <= s1_last_reg;
            out_pixel_reg <= out_pixel_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;

`ifndef SYNTHESIS
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cmd_item.op == lr_pkg::OP_TICK && !busy_reg) |=> !s1_valid_reg)
        else $error("tick while idle produced a pixel");

    a_point_line: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cmd_item.op == lr_pkg::OP_LINE && cmd_item.first_last)
            |=> (!busy_reg && s1_valid_reg && s1_last_reg))
        else $error("single point line left the stepper busy");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cmd_item.op == lr_pkg::OP_TICK && busy_reg && step_last) |=> !busy_reg)
        else $error("stepper still busy after the final pixel");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(s1_valid_reg) && $stable(s2_valid_reg)))
        else $error("pipeline moved while the output was stalled");
`endif

endmodule

`default_nettype wire

[test/line_check_pkg.sv]
// Pixel tracker for the line rasterizer testbench: predicts and checks pixels.
// Depends on lr_pkg for the item, pixel and register types.
`timescale 1ns / 1ps

package line_check_pkg;

    import lr_pkg::*;

    class pixel_tracker;

        // Register copies, as written through the configuration port.
        addr_t  frame_base;
        pitch_t row_pitch;

        // Line state, mirroring what the stepper holds.
        bit     drawing;
        coord_t cur_x;
        coord_t cur_y;
        coord_t major_end;
        bit     steep;
        bit     y_falls;
        int     decision;
        int     straight_step;
        int     diagonal_step;
        color_t colour;

        // Pixels predicted but not yet seen on the output.
        pixel_t pending_pixels[$];

        int mismatches;
        int lines_started;
        int pixels_predicted;
        int pixels_checked;
        int idle_ticks;

        function new();
            frame_base = '0;
            row_pitch  = PITCH_RESET;
            drawing    = 1'b0;
            cur_x      = '0;
            cur_y      = '0;
            major_end  = '0;
            steep      = 1'b0;
            y_falls    = 1'b0;
            decision   = 0;
            straight_step = 0;
            diagonal_step = 0;
            colour     = '0;
            mismatches = 0;
            lines_started    = 0;
            pixels_predicted = 0;
            pixels_checked   = 0;
            idle_ticks       = 0;
        endfunction

        function void set_register(cfg_reg_e index, addr_t data);
            if (index == REG_FRAME_BASE)
                frame_base = data;
            else
                row_pitch = pitch_t'(data);
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        // Notes an accepted item and queues the pixel it should produce, if any.
        function void take_item(item_t it);
            coord_t x1;
            coord_t y1;
            coord_t x2;
            coord_t y2;
            int     dx;
            int     ady;
            int     major;
            int     minor;
            bit     diag;
            pixel_t px;
            logic [31:0] address;

            if (it.op == OP_LINE)
            begin
                // Order the endpoints so that x never decreases along the line.
                if (it.start_x <= it.end_x)
                begin
                    x1 = it.start_x;
                    y1 = it.start_y;
                    x2 = it.end_x;
                    y2 = it.end_y;
                end
                else
                begin
                    x1 = it.end_x;
                    y1 = it.end_y;
                    x2 = it.start_x;
                    y2 = it.start_y;
                end
                dx      = int'(x2) - int'(x1);
                y_falls = y2 < y1;
                ady     = y_falls ? int'(y1) - int'(y2) : int'(y2) - int'(y1);
                steep   = ady > dx;
                major   = steep ? ady : dx;
                minor   = steep ? dx : ady;
                decision      = 2 * minor - major;
                straight_step = 2 * minor;
                diagonal_step = 2 * (minor - major);
                major_end = steep ? y2 : x2;
                cur_x  = x1;
                cur_y  = y1;
                colour = it.pen_color;
                lines_started++;
            end
            else if (!drawing)
            begin
                idle_ticks++;
                return;
            end
            else
            begin
                // One step along the major axis; the minor axis follows when the
                // decision value was strictly positive, so a tie steps straight.
                diag = decision > 0;
                decision += diag ? diagonal_step : straight_step;
                if (steep)
                begin
                    cur_y = y_falls ? cur_y - 1'b1 : cur_y + 1'b1;
                    if (diag)
                        cur_x = cur_x + 1'b1;
                end
                else
                begin
                    cur_x = cur_x + 1'b1;
                    if (diag)
                        cur_y = y_falls ? cur_y - 1'b1 : cur_y + 1'b1;
                end
            end

            drawing = (steep ? cur_y : cur_x) != major_end;

            // The address wraps at the width of the address field.
            address = 32'(frame_base) + 32'(row_pitch) * 32'(cur_y) + 32'(cur_x);
            px.pixel_x       = cur_x;
            px.pixel_y       = cur_y;
            px.pixel_address = addr_t'(address);
            px.pixel_color   = colour;
            px.last          = !drawing;
            pending_pixels.push_back(px);
            pixels_predicted++;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // Compares one transferred pixel with the oldest prediction.
        task check_pixel(pixel_t got);
            pixel_t want;
            if (pending_pixels.size() == 0)
            begin
                report($sformatf("pixel (%0d,%0d) arrived with none predicted",
                                 got.pixel_x, got.pixel_y));
                return;
            end
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (got.pixel_x !== want.pixel_x)
                report($sformatf("pixel_x %0d, predicted %0d", got.pixel_x, want.pixel_x));
            if (got.pixel_y !== want.pixel_y)
                report($sformatf("pixel_y %0d, predicted %0d", got.pixel_y, want.pixel_y));
            if (got.pixel_address !== want.pixel_address)
                report($sformatf("pixel_address %h, predicted %h",
                                 got.pixel_address, want.pixel_address));
            if (got.pixel_color !== want.pixel_color)
                report($sformatf("pixel_color %h, predicted %h",
                                 got.pixel_color, want.pixel_color));
            if (got.last !== want.last)
                report($sformatf("last %b, predicted %b at (%0d,%0d)",
                                 got.last, want.last, want.pixel_x, want.pixel_y));
        endtask

        // Anything still predicted at the end never came out.
        task check_nothing_left();
            if (pending_pixels.size() != 0)
                report($sformatf("%0d predicted pixels never arrived",
                                 pending_pixels.size()));
        endtask

    endclass

endpackage

[test/tb_line_rasterizer.sv]
// Self-checking testbench for the line rasterizer: directed lines, then random ones.
// Depends on lr_pkg, line_check_pkg and the line_rasterizer RTL.
`timescale 1ns / 1ps

module tb_line_rasterizer;

    import lr_pkg::*;
    import line_check_pkg::*;

    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int ITEM_TARGET   = 1650;
    localparam int RANDOM_PHASES = 6;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int IDLE_PERCENT  = 23;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    item_t    in_item;
    logic     out_valid;
    logic     out_ready;
    pixel_t   out_pixel;
    logic     cfg_valid;
    logic     cfg_ready;
    cfg_reg_e cfg_index;
    addr_t    cfg_data;

    bit           gaps_on;
    int           cycle_count;
    int           settings_used;
    pixel_tracker tracker;

    line_rasterizer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_pixel (out_pixel),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    always #5 clk = ~clk;

    // Run limit, in case the block stops transferring.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles without finishing.", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The receiver stalls at random unless gaps are switched off.
    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= !gaps_on || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Every pixel transfer is checked against the prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_pixel(out_pixel);
    end

    function automatic item_t random_item();
        item_t it;
        it.op        = op_e'($urandom_range(1));
        it.start_x   = coord_t'($urandom);
        it.start_y   = coord_t'($urandom);
        it.end_x     = coord_t'($urandom);
        it.end_y     = coord_t'($urandom);
        it.pen_color = color_t'($urandom);
        return it;
    endfunction

    // A coordinate within span of c, held inside the frame.
    function automatic coord_t near(coord_t c, int span);
        int v;
        v = int'(c) + int'($urandom_range(2 * span)) - span;
        if (v < 0)
            v = 0;
        else if (v > COORD_MAX)
            v = COORD_MAX;
        return coord_t'(v);
    endfunction

    // Offers one item and returns once it has been transferred.
    task automatic send_item(input item_t it);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.take_item(it);
    endtask

    // A line command followed by a number of ticks; the tick fields are noise.
    task automatic send_line(input coord_t sx, input coord_t sy, input coord_t ex,
                             input coord_t ey, input color_t c, input int ticks);
        item_t it;
        it = random_item();
        it.op        = OP_LINE;
        it.start_x   = sx;
        it.start_y   = sy;
        it.end_x     = ex;
        it.end_y     = ey;
        it.pen_color = c;
        send_item(it);
        repeat (ticks)
        begin
            it = random_item();
            it.op = OP_TICK;
            send_item(it);
        end
    endtask

    // Mostly short lines run to their end; some are cut short by the next
    // command and some are followed by ticks that find the block idle.
    task automatic random_line();
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        int     sel;
        int     span;
        int     len;
        int     ticks;
        sel  = $urandom_range(99);
        span = (sel < 85) ? 12 : (sel < 98) ? 60 : COORD_MAX;
        sx   = coord_t'($urandom);
        sy   = coord_t'($urandom);
        ex   = near(sx, span);
        ey   = near(sy, span);
        len  = (sx > ex) ? int'(sx) - int'(ex) : int'(ex) - int'(sx);
        if (sy > ey && int'(sy) - int'(ey) > len)
            len = int'(sy) - int'(ey);
        else if (ey > sy && int'(ey) - int'(sy) > len)
            len = int'(ey) - int'(sy);
        sel = $urandom_range(99);
        if (sel < 12)
            ticks = $urandom_range(len);
        else if (sel < 22)
            ticks = len + $urandom_range(1, 3);
        else
            ticks = len;
        send_line(sx, sy, ex, ey, color_t'($urandom), ticks);
    endtask

    task automatic write_register(input cfg_reg_e index, input addr_t data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.set_register(index, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering items and waits until every predicted pixel has come out.
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        item_t it;
        addr_t base;
        addr_t pitch;
        int    phase;
        int    budget;

        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        out_ready   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_FRAME_BASE;
        cfg_data    = '0;
        gaps_on     = 1'b1;
        cycle_count = 0;
        tracker     = new();

        // Reset, released on a falling edge.
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed lines at the reset register values.
        it = random_item();
        it.op = OP_TICK;
        send_item(it);                                  // tick with no line drawn
        send_line(0, 0, 0, 0, 8'h00, 0);                // single point at the origin
        send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 8'hFF, 1);
        send_line(0, 6, 3, 5, 8'h5A, 3);                // shallow, y falling
        send_line(COORD_MAX, 0, COORD_MAX - 2, 4, 8'hA5, 4);  // steep, endpoints swapped
        send_line(100, 1019, 104, 1021, 8'h0F, 4);      // decision ties along the way
        send_line(500, 500, 502, 505, 8'hF0, 1);        // steep rising, then abandoned
        send_line(2, COORD_MAX, 0, COORD_MAX, 8'h33, 3); // flat on the bottom row
        settle();
        settings_used = 1;

        // Random phases, each under its own register setting.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    base  = addr_t'((1 << ADDR_BITS) - 1);
                    pitch = addr_t'({pitch_t'($urandom), pitch_t'('1)});
                end
                1:
                begin
                    base  = '0;
                    pitch = '0;
                end
                2:
                begin
                    base  = addr_t'($urandom);
                    pitch = addr_t'(1);
                end
                default:
                begin
                    base  = addr_t'($urandom);
                    pitch = addr_t'($urandom);
                end
            endcase
            if ($urandom_range(1))
            begin
                write_register(REG_FRAME_BASE, base);
                write_register(REG_ROW_PITCH, pitch);
            end
            else
            begin
                write_register(REG_ROW_PITCH, pitch);
                write_register(REG_FRAME_BASE, base);
            end
            settings_used++;

            // One phase runs with no idling on either side.
            gaps_on = (phase != 3);
            budget  = tracker.pixels_predicted + ITEM_TARGET / RANDOM_PHASES;
            while (tracker.pixels_predicted < budget)
                random_line();
            settle();
        end

        tracker.check_nothing_left();
        $display("Drew %0d lines giving %0d pixels (%0d checked) under %0d register settings;",
                 tracker.lines_started, tracker.pixels_predicted, tracker.pixels_checked,
                 settings_used);
        $display("%0d ticks found the block idle, %0d mismatches in %0d cycles.",
                 tracker.idle_ticks, tracker.mismatches, cycle_count);
        if (tracker.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
